// ===== rtl/core/mtick_pkg.sv =====
package mtick_pkg;

    localparam int unsigned TIME_W      = 32;
    localparam int unsigned REG_IDX_W   = 3;
    localparam int unsigned ACTIVE_W    = 3;
    localparam int unsigned PERIOD_REGS = 4;
    localparam int unsigned MASK_W      = 4;

    typedef logic [TIME_W-1:0] t_time;

    // Register indexes of the configuration port
    typedef enum logic [REG_IDX_W-1:0] {
        REG_ACTIVE_SLOTS     = 3'd0,
        REG_HEARTBEAT_ON     = 3'd1,
        REG_HEARTBEAT_PERIOD = 3'd2,
        REG_PERIOD_SLOT0     = 3'd3,
        REG_PERIOD_SLOT1     = 3'd4,
        REG_PERIOD_SLOT2     = 3'd5,
        REG_PERIOD_SLOT3     = 3'd6
    } t_reg_idx;

    // Item action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef struct packed {
        logic [ACTIVE_W-1:0]               active_slots;
        logic                              heartbeat_on;
        t_time                             heartbeat_period;
        logic [PERIOD_REGS-1:0][TIME_W-1:0] period;
    } t_cfg;

    typedef struct packed {
        logic              wrapped;
        logic [MASK_W-1:0] fire_mask;
        logic              heartbeat_fired;
        t_time             time_echo;
    } t_result;

endpackage

// ===== rtl/core/mtick_if.sv =====
interface mtick_in_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [mtick_pkg::TIME_W-1:0] now_us;

    modport source (output valid, action, now_us, input ready);
    modport sink   (input valid, action, now_us, output ready);
endinterface

interface mtick_out_if;
    logic                         valid;
    logic                         ready;
    logic                         wrapped;
    logic [mtick_pkg::MASK_W-1:0] fire_mask;
    logic                         heartbeat_fired;
    logic [mtick_pkg::TIME_W-1:0] time_echo;

    modport source (output valid, wrapped, fire_mask, heartbeat_fired, time_echo,
                    input ready);
    modport sink   (input valid, wrapped, fire_mask, heartbeat_fired, time_echo,
                    output ready);
endinterface

interface mtick_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mtick_pkg::REG_IDX_W-1:0] index;
    logic [mtick_pkg::TIME_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mtick_cfg.sv =====
module mtick_cfg #(
    parameter int unsigned SLOT_COUNT = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mtick_cfg_if.sink        i_cfg,
    output mtick_pkg::t_cfg  o_cfg
);

    mtick_pkg::t_cfg r_cfg;
    mtick_pkg::t_cfg n_cfg;
    logic            wr;

    assign i_cfg.ready = 1'b1;
    assign wr          = i_cfg.valid;

    // Decode the register write; indexes beyond the list are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            unique case (mtick_pkg::t_reg_idx'(i_cfg.index))
                mtick_pkg::REG_ACTIVE_SLOTS:
                    n_cfg.active_slots = i_cfg.data[mtick_pkg::ACTIVE_W-1:0];
                mtick_pkg::REG_HEARTBEAT_ON:
                    n_cfg.heartbeat_on = i_cfg.data[0];
                mtick_pkg::REG_HEARTBEAT_PERIOD:
                    n_cfg.heartbeat_period = i_cfg.data;
                mtick_pkg::REG_PERIOD_SLOT0:
                    if (SLOT_COUNT > 0) n_cfg.period[0] = i_cfg.data;
                mtick_pkg::REG_PERIOD_SLOT1:
                    if (SLOT_COUNT > 1) n_cfg.period[1] = i_cfg.data;
                mtick_pkg::REG_PERIOD_SLOT2:
                    if (SLOT_COUNT > 2) n_cfg.period[2] = i_cfg.data;
                mtick_pkg::REG_PERIOD_SLOT3:
                    if (SLOT_COUNT > 3) n_cfg.period[3] = i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/mtick_eval.sv =====
module mtick_eval #(
    parameter int unsigned SLOT_COUNT = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mtick_pkg::t_cfg        i_cfg,
    input  logic                   i_advance,
    input  logic                   i_action,
    input  mtick_pkg::t_time       i_now,
    output mtick_pkg::t_result     o_result
);

    localparam int unsigned SLOT_IDX_W = 5;

    mtick_pkg::t_time r_last_seen;
    mtick_pkg::t_time r_hb_last;
    mtick_pkg::t_time r_slot_last [SLOT_COUNT];

    logic                  is_tick;
    logic                  wrap;
    logic                  resync;
    logic                  hb_fire;
    logic [SLOT_COUNT-1:0] slot_fire;
    mtick_pkg::t_time      hb_elapsed;

    // A start or a backwards timestamp re-bases every last-fire time
    assign is_tick = (i_action == mtick_pkg::ACT_TICK);
    assign wrap    = is_tick && (i_now < r_last_seen);
    assign resync  = !is_tick || wrap;

    assign hb_elapsed = i_now - r_hb_last;
    assign hb_fire    = is_tick && !wrap && i_cfg.heartbeat_on &&
                        (hb_elapsed > i_cfg.heartbeat_period);

    // One subtract and compare per slot
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
        mtick_pkg::t_time period;
        mtick_pkg::t_time elapsed;
        logic             enabled;

        if (g < mtick_pkg::PERIOD_REGS) begin : g_reg
            assign period = i_cfg.period[g];
        end else begin : g_zero
            assign period = '0;
        end

        assign enabled      = SLOT_IDX_W'(g) <
                              {{(SLOT_IDX_W-mtick_pkg::ACTIVE_W){1'b0}}, i_cfg.active_slots};
        assign elapsed      = i_now - r_slot_last[g];
        assign slot_fire[g] = is_tick && !wrap && enabled && (elapsed > period);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_slot_last[g] <= '0;
            end else if (i_advance && (resync || slot_fire[g])) begin
                r_slot_last[g] <= i_now;
            end
        end
    end

    // Report the first four slots only
    for (genvar m = 0; m < mtick_pkg::MASK_W; m++) begin : g_mask
        if (m < SLOT_COUNT) begin : g_on
            assign o_result.fire_mask[m] = slot_fire[m];
        end else begin : g_off
            assign o_result.fire_mask[m] = 1'b0;
        end
    end

    // Heartbeat and last-seen timestamps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seen <= '0;
            r_hb_last   <= '0;
        end else if (i_advance) begin
            r_last_seen <= i_now;
            if (resync || hb_fire) begin
                r_hb_last <= i_now;
            end
        end
    end

    assign o_result.wrapped         = wrap;
    assign o_result.heartbeat_fired = hb_fire;
    assign o_result.time_echo       = i_now;

endmodule

// ===== rtl/core/multi_slot_periodic_tick_scheduler_top.sv =====
// Channel   Dir  Payload                                          Transfer
// i_in      in   action, now_us                                   valid & ready
// o_out     out  wrapped, fire_mask, heartbeat_fired, time_echo   valid & ready
// i_cfg     in   index (3 b), data (32 b)                         valid & ready
//
// One item per cycle sustained while the output is not stalled.
// The input register feeds one subtract-and-compare per slot, and the result
// register takes the outcome while slot state updates in the same cycle.
// Synchronous active-low reset clears the valid flags, slot state and config registers.
// A stalled output holds its result; input is still taken while the result
// register drains in the same cycle.
module multi_slot_periodic_tick_scheduler_top #(
    parameter int unsigned SLOT_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtick_in_if.sink    i_in,
    mtick_out_if.source o_out,
    mtick_cfg_if.sink   i_cfg
);

    mtick_pkg::t_cfg    cfg;
    mtick_pkg::t_result result;

    logic               r_in_valid;
    logic               r_in_action;
    mtick_pkg::t_time   r_in_now;
    logic               r_out_valid;
    mtick_pkg::t_result r_out;
    logic               advance;

    mtick_cfg #(.SLOT_COUNT(SLOT_COUNT)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    mtick_eval #(.SLOT_COUNT(SLOT_COUNT)) u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_action  (r_in_action),
        .i_now     (r_in_now),
        .o_result  (result)
    );

    // Move the held item forward when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_action <= i_in.action;
            r_in_now    <= i_in.now_us;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.wrapped         = r_out.wrapped;
    assign o_out.fire_mask       = r_out.fire_mask;
    assign o_out.heartbeat_fired = r_out.heartbeat_fired;
    assign o_out.time_echo       = r_out.time_echo;

endmodule

// ===== rtl/core/mtick_chk.sv =====
module mtick_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_out_wrapped,
    input logic [mtick_pkg::MASK_W-1:0] i_out_fire_mask,
    input logic                         i_out_heartbeat_fired,
    input logic [mtick_pkg::TIME_W-1:0] i_out_time_echo
);

    logic                   r_prev_valid;
    mtick_pkg::t_time       r_prev_time;
    logic                   out_xfer;

    assign out_xfer = i_out_valid && i_out_ready;

    // Track the timestamp of the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
        end else if (out_xfer) begin
            r_prev_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_xfer) begin
            r_prev_time <= i_out_time_echo;
        end
    end

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("stalled result dropped");

    a_wrap_fires_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_wrapped |-> (i_out_fire_mask == '0) && !i_out_heartbeat_fired)
        else $error("wrap result reports a firing");

    a_wrap_goes_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && i_out_wrapped |-> r_prev_valid && (i_out_time_echo < r_prev_time))
        else $error("wrap without a backwards timestamp");

endmodule

bind multi_slot_periodic_tick_scheduler_top mtick_chk u_chk (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_out_valid           (o_out.valid),
    .i_out_ready           (o_out.ready),
    .i_out_wrapped         (o_out.wrapped),
    .i_out_fire_mask       (o_out.fire_mask),
    .i_out_heartbeat_fired (o_out.heartbeat_fired),
    .i_out_time_echo       (o_out.time_echo)
);

// ===== tb/multi_slot_periodic_tick_scheduler_top_tb.sv =====
`timescale 1ns / 1ps

module multi_slot_periodic_tick_scheduler_top_tb;

    localparam int unsigned SLOTS        = 4;
    localparam int unsigned PHASES       = 12;
    localparam int unsigned PHASE_ITEMS  = 70;
    localparam int unsigned HOLD_PHASE   = 3;
    localparam int unsigned DRAIN_PHASE  = 5;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned SETTLE_WAIT  = 4;
    localparam int unsigned PLAN_ROWS    = 29;
    // Index past the register list; writes to it must be dropped
    localparam logic [mtick_pkg::REG_IDX_W-1:0] REG_SPARE = 3'd7;
    // Short names for the item actions in the table
    localparam logic START = mtick_pkg::ACT_START;
    localparam logic TICK  = mtick_pkg::ACT_TICK;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_TYPED,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind                        kind;
        logic                             action;
        logic [mtick_pkg::REG_IDX_W-1:0]  idx;
        mtick_pkg::t_time                 value;
        logic                             wrapped;
        logic [mtick_pkg::MASK_W-1:0]     mask;
        logic                             hb;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mtick_in_if  in_ch ();
    mtick_out_if out_ch ();
    mtick_cfg_if cfg_ch ();

    multi_slot_periodic_tick_scheduler_top #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    always #10 i_clk = ~i_clk;

    // Scheduler shadow: configuration and timing state
    mtick_pkg::t_cfg    sched_cfg = '0;
    mtick_pkg::t_time   seen_time = '0;
    mtick_pkg::t_time   hb_last   = '0;
    mtick_pkg::t_time   slot_last [SLOTS];

    mtick_pkg::t_result expected_fires [$];
    int      mismatch_count = 0;
    bit      in_idle_on     = 1'b1;
    bit      out_idle_on    = 1'b1;
    bit      hold_req       = 1'b0;

    // Compute the result of one item and advance the shadow timing state
    function automatic mtick_pkg::t_result advance_schedule(input logic act,
                                                            input mtick_pkg::t_time stamp);
        mtick_pkg::t_result res;
        int unsigned        live;
        res           = '0;
        res.time_echo = stamp;
        if (act == mtick_pkg::ACT_START || stamp < seen_time) begin
            res.wrapped = (act == mtick_pkg::ACT_TICK);
            hb_last     = stamp;
            for (int i = 0; i < SLOTS; i++) slot_last[i] = stamp;
        end else begin
            if (sched_cfg.heartbeat_on &&
                mtick_pkg::t_time'(stamp - hb_last) > sched_cfg.heartbeat_period) begin
                hb_last             = stamp;
                res.heartbeat_fired = 1'b1;
            end
            live = (sched_cfg.active_slots > SLOTS) ? SLOTS : sched_cfg.active_slots;
            for (int i = 0; i < live; i++) begin
                if (mtick_pkg::t_time'(stamp - slot_last[i]) > sched_cfg.period[i]) begin
                    slot_last[i]     = stamp;
                    res.fire_mask[i] = 1'b1;
                end
            end
        end
        seen_time = stamp;
        return res;
    endfunction

    function automatic void apply_register(input logic [mtick_pkg::REG_IDX_W-1:0] idx,
                                           input mtick_pkg::t_time data);
        case (idx)
            mtick_pkg::REG_ACTIVE_SLOTS:
                sched_cfg.active_slots = data[mtick_pkg::ACTIVE_W-1:0];
            mtick_pkg::REG_HEARTBEAT_ON:
                sched_cfg.heartbeat_on = data[0];
            mtick_pkg::REG_HEARTBEAT_PERIOD:
                sched_cfg.heartbeat_period = data;
            mtick_pkg::REG_PERIOD_SLOT0, mtick_pkg::REG_PERIOD_SLOT1,
            mtick_pkg::REG_PERIOD_SLOT2, mtick_pkg::REG_PERIOD_SLOT3:
                sched_cfg.period[idx - mtick_pkg::REG_PERIOD_SLOT0] = data;
            default: ;
        endcase
    endfunction

    function automatic mtick_pkg::t_time pick_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom();
            3:       return $urandom_range(0, 400);
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    // Leave cfg valid high; the caller drops it after the last write of a batch
    task automatic write_register(input logic [mtick_pkg::REG_IDX_W-1:0] idx,
                                  input mtick_pkg::t_time data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_register(idx, data);
    endtask

    task automatic offer_item(input logic act, input mtick_pkg::t_time stamp,
                              input bit typed, input mtick_pkg::t_result typed_res);
        mtick_pkg::t_result want;
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.now_us <= stamp;
        do @(posedge i_clk); while (!in_ch.ready);
        want = advance_schedule(act, stamp);
        if (typed) want = typed_res;
        expected_fires.push_back(want);
        // Random sender gap after the transfer
        if (in_idle_on && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // Drain every outstanding result, then let the pipeline go quiet
    task automatic settle_idle();
        in_ch.valid <= 1'b0;
        while (expected_fires.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic check_field(input string label, input mtick_pkg::t_time want,
                               input mtick_pkg::t_time got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, label, want, got);
            mismatch_count++;
        end
    endtask

    t_row directed_plan [0:PLAN_ROWS-1] = '{
        // Power-up configuration: nothing enabled
        '{ROW_TYPED, TICK,  mtick_pkg::REG_ACTIVE_SLOTS,     32'h0000_0000, 1'b0, 4'h0, 1'b0},
        '{ROW_TYPED, TICK,  mtick_pkg::REG_ACTIVE_SLOTS,     32'hFFFF_FFFF, 1'b0, 4'h0, 1'b0},
        '{ROW_TYPED, TICK,  mtick_pkg::REG_ACTIVE_SLOTS,     32'h0000_0000, 1'b1, 4'h0, 1'b0},
        '{ROW_TYPED, START, mtick_pkg::REG_ACTIVE_SLOTS,     32'hFFFF_FFFF, 1'b0, 4'h0, 1'b0},
        // All slots on, periods at both extremes
        '{ROW_WRITE, START, mtick_pkg::REG_ACTIVE_SLOTS,     32'd4,         1'b0, 4'h0, 1'b0},
        '{ROW_WRITE, START, mtick_pkg::REG_HEARTBEAT_ON,     32'd1,         1'b0, 4'h0, 1'b0},
        '{ROW_WRITE, START, mtick_pkg::REG_HEARTBEAT_PERIOD, 32'd0,         1'b0, 4'h0, 1'b0},
        '{ROW_WRITE, START, mtick_pkg::REG_PERIOD_SLOT0,     32'd0,         1'b0, 4'h0, 1'b0},
        '{ROW_WRITE, START, mtick_pkg::REG_PERIOD_SLOT1,     32'd5,         1'b0, 4'h0, 1'b0},
        '{ROW_WRITE, START, mtick_pkg::REG_PERIOD_SLOT2,     32'hFFFF_FFFF, 1'b0, 4'h0, 1'b0},
        '{ROW_WRITE, START, mtick_pkg::REG_PERIOD_SLOT3,     32'hFFFF_FFFE, 1'b0, 4'h0, 1'b0},
        '{ROW_TYPED, TICK,  mtick_pkg::REG_ACTIVE_SLOTS,     32'h0000_0000, 1'b1, 4'h0, 1'b0},
        '{ROW_ITEM,  TICK,  mtick_pkg::REG_ACTIVE_SLOTS,     32'h0000_0000, 1'b0, 4'h0, 1'b0},
        '{ROW_ITEM,  TICK,  mtick_pkg::REG_ACTIVE_SLOTS,     32'h0000_0001, 1'b0, 4'h0, 1'b0},
        '{ROW_ITEM,  TICK,  mtick_pkg::REG_ACTIVE_SLOTS,     32'h0000_0007, 1'b0, 4'h0, 1'b0},
        '{ROW_TYPED, START, mtick_pkg::REG_ACTIVE_SLOTS,     32'h0000_0000, 1'b0, 4'h0, 1'b0},
        '{ROW_ITEM,  TICK,  mtick_pkg::REG_ACTIVE_SLOTS,     32'hFFFF_FFFF, 1'b0, 4'h0, 1'b0},
        // Oversized active count, heartbeat off, write past the register list
        '{ROW_WRITE, START, mtick_pkg::REG_ACTIVE_SLOTS,     32'd7,         1'b0, 4'h0, 1'b0},
        '{ROW_WRITE, START, mtick_pkg::REG_HEARTBEAT_ON,     32'd0,         1'b0, 4'h0, 1'b0},
        '{ROW_WRITE, START, REG_SPARE,                       32'hDEAD_BEEF, 1'b0, 4'h0, 1'b0},
        '{ROW_TYPED, START, mtick_pkg::REG_ACTIVE_SLOTS,     32'd10,        1'b0, 4'h0, 1'b0},
        '{ROW_ITEM,  TICK,  mtick_pkg::REG_ACTIVE_SLOTS,     32'd20,        1'b0, 4'h0, 1'b0},
        '{ROW_ITEM,  TICK,  mtick_pkg::REG_ACTIVE_SLOTS,     32'd20,        1'b0, 4'h0, 1'b0},
        '{ROW_TYPED, TICK,  mtick_pkg::REG_ACTIVE_SLOTS,     32'd9,         1'b1, 4'h0, 1'b0},
        // One slot, heartbeat with the largest period
        '{ROW_WRITE, START, mtick_pkg::REG_ACTIVE_SLOTS,     32'd1,         1'b0, 4'h0, 1'b0},
        '{ROW_WRITE, START, mtick_pkg::REG_HEARTBEAT_ON,     32'd1,         1'b0, 4'h0, 1'b0},
        '{ROW_WRITE, START, mtick_pkg::REG_HEARTBEAT_PERIOD, 32'hFFFF_FFFF, 1'b0, 4'h0, 1'b0},
        '{ROW_ITEM,  TICK,  mtick_pkg::REG_ACTIVE_SLOTS,     32'd30,        1'b0, 4'h0, 1'b0},
        '{ROW_ITEM,  TICK,  mtick_pkg::REG_ACTIVE_SLOTS,     32'h8000_0000, 1'b0, 4'h0, 1'b0}
    };

    // Result monitor: match each output transfer against the oldest prediction
    always @(posedge i_clk) begin
        mtick_pkg::t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_fires.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %0h/%0h/%0h/%0h",
                         $time, out_ch.wrapped, out_ch.fire_mask,
                         out_ch.heartbeat_fired, out_ch.time_echo);
                mismatch_count++;
            end else begin
                want = expected_fires.pop_front();
                check_field("wrapped", mtick_pkg::t_time'(want.wrapped),
                            mtick_pkg::t_time'(out_ch.wrapped));
                check_field("fire_mask", mtick_pkg::t_time'(want.fire_mask),
                            mtick_pkg::t_time'(out_ch.fire_mask));
                check_field("heartbeat_fired", mtick_pkg::t_time'(want.heartbeat_fired),
                            mtick_pkg::t_time'(out_ch.heartbeat_fired));
                check_field("time_echo", want.time_echo, out_ch.time_echo);
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (out_idle_on && $urandom_range(0, 9) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    initial begin
        #10_000_000;
        $display("multi_slot_periodic_tick_scheduler_top verification failed");
        $finish;
    end

    initial begin
        t_row               row;
        mtick_pkg::t_result typed_res;
        bit                 after_item;
        logic               act;
        mtick_pkg::t_time   stamp;
        mtick_pkg::t_time   cursor;
        int                 sel;

        for (int i = 0; i < SLOTS; i++) slot_last[i] = '0;
        after_item = 1'b0;
        cursor     = '0;
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.action <= mtick_pkg::ACT_START;
        in_ch.now_us <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= mtick_pkg::REG_ACTIVE_SLOTS;
        cfg_ch.data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (directed_plan[r]) begin
            row = directed_plan[r];
            if (row.kind == ROW_WRITE) begin
                if (after_item) settle_idle();
                write_register(row.idx, row.value);
                after_item = 1'b0;
            end else begin
                cfg_ch.valid <= 1'b0;
                typed_res                 = '0;
                typed_res.wrapped         = row.wrapped;
                typed_res.fire_mask       = row.mask;
                typed_res.heartbeat_fired = row.hb;
                typed_res.time_echo       = row.value;
                offer_item(row.action, row.value, row.kind == ROW_TYPED, typed_res);
                after_item = 1'b1;
            end
        end

        // Random phases, each with a fresh configuration
        for (int ph = 0; ph < PHASES; ph++) begin
            settle_idle();
            in_idle_on  = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
            out_idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int k = mtick_pkg::REG_ACTIVE_SLOTS; k <= mtick_pkg::REG_PERIOD_SLOT3; k++) begin
                if (k == mtick_pkg::REG_ACTIVE_SLOTS || k == mtick_pkg::REG_HEARTBEAT_ON)
                    write_register(k[mtick_pkg::REG_IDX_W-1:0], $urandom());
                else
                    write_register(k[mtick_pkg::REG_IDX_W-1:0], pick_period());
            end
            if ($urandom_range(0, 2) == 0) write_register(REG_SPARE, $urandom());
            cfg_ch.valid <= 1'b0;

            if (ph == HOLD_PHASE) hold_req = 1'b1;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Sender pause: wait for every outstanding result
                if (ph == DRAIN_PHASE && k == PHASE_ITEMS / 2) begin
                    in_ch.valid <= 1'b0;
                    while (expected_fires.size() != 0) @(posedge i_clk);
                end
                sel = $urandom_range(0, 99);
                act = mtick_pkg::ACT_TICK;
                if (sel < 4) begin
                    act = mtick_pkg::ACT_START;
                    if ($urandom_range(0, 1) == 0) cursor = $urandom();
                end else if (sel < 8) begin
                    cursor = cursor - $urandom_range(1, 100);
                end else if (sel < 11) begin
                    act    = 1'($urandom_range(0, 1));
                    cursor = $urandom();
                end else if (sel < 13) begin
                    cursor = 32'hFFFF_FFFF - $urandom_range(0, 60);
                end else if (sel < 16) begin
                    cursor = cursor + $urandom();
                end else begin
                    cursor = cursor + $urandom_range(0, 25);
                end
                stamp = cursor;
                offer_item(act, stamp, 1'b0, '0);
            end
        end

        settle_idle();
        if (mismatch_count == 0)
            $display("multi_slot_periodic_tick_scheduler_top verification clean");
        else
            $display("multi_slot_periodic_tick_scheduler_top verification failed");
        $finish;
    end

endmodule
